[hw/rtl/kse_pkg.sv]
// Shared types, key codes and segment fonts for the keypad entry block.
package kse_pkg;

  typedef logic [3:0] key_t;

  // Key codes
  localparam key_t KEY_ZERO = 4'd0;
  localparam key_t KEY_NINE = 4'd9;
  localparam key_t KEY_DASH = 4'd10;
  localparam key_t KEY_DOT  = 4'd11;
  localparam key_t KEY_NONE = 4'd12;

  // Active-low segment patterns, dot in bit 7
  localparam logic [7:0] SEG_DARK   = 8'hFF;
  localparam logic [7:0] SEG_DASH   = 8'hBF;
  localparam logic [7:0] SEG_DOT    = 8'h7F;
  localparam logic [7:0] SEG_LOW_H  = 8'h8B;
  localparam logic [7:0] SEG_SECOND = 8'h9B;

  // LED level sets, bit 0 is the first LED
  localparam logic [2:0] LED_ALL_OFF = 3'b111;
  localparam logic [2:0] LED_SYMBOL  = 3'b100;
  localparam logic [2:0] LED_LETTER  = 3'b011;

  // Entry modes
  localparam logic MODE_DIGIT  = 1'b0;
  localparam logic MODE_LETTER = 1'b1;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic button;
    key_t key;
  } item_t;

  function automatic logic [7:0] digit_font(input key_t k);
    logic [7:0] p;
    p = SEG_DARK;
    unique case (k)
      4'd0: p = 8'hC0;
      4'd1: p = 8'hF9;
      4'd2: p = 8'hA4;
      4'd3: p = 8'hB0;
      4'd4: p = 8'h99;
      4'd5: p = 8'h92;
      4'd6: p = 8'h82;
      4'd7: p = 8'hF8;
      4'd8: p = 8'h80;
      4'd9: p = 8'h90;
      default: p = SEG_DARK;
    endcase
    return p;
  endfunction

  // Letters A..F on keys 1..6
  function automatic logic [7:0] letter_font(input key_t k);
    logic [7:0] p;
    p = SEG_DARK;
    unique case (k)
      4'd1: p = 8'h88;
      4'd2: p = 8'h83;
      4'd3: p = 8'hC6;
      4'd4: p = 8'hA1;
      4'd5: p = 8'h86;
      4'd6: p = 8'h8E;
      default: p = SEG_DARK;
    endcase
    return p;
  endfunction

endpackage

[hw/rtl/kse_front.sv]
// Front end: accepts scan ticks and decodes the keypad snapshot into a key code.
module kse_front import kse_pkg::*; (
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        button_level,
  input  logic [11:0] key_matrix,
  input  logic        q_full,
  output logic        q_push,
  output item_t       q_item
);

  key_t key;

  // Last closed switch in scan order wins, i.e. the highest set bit.
  always_comb begin
    key = KEY_NONE;
    for (int b = 0; b < 12; b++) begin
      if (key_matrix[b]) begin
        if ((b % 4) < 3) begin
          key = 4'(((b % 4) * 3) + (b / 4) + 1);
        end else if ((b / 4) == 0) begin
          key = KEY_DASH;
        end else if ((b / 4) == 1) begin
          key = KEY_ZERO;
        end else begin
          key = KEY_DOT;
        end
      end
    end
  end

  assign in_ready      = !q_full;
  assign q_push        = in_valid && !q_full;
  assign q_item.button = button_level;
  assign q_item.key    = key;

endmodule

[hw/rtl/kse_queue.sv]
// Short FIFO that decouples the decode front from the state back end.
module kse_queue import kse_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t pop_item,
  output logic  full,
  output logic  empty
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  item_t           mem [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full     = (count == CntW'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/kse_back.sv]
// Back end: press tracking, mode and cursor state, display and LED result register.
module kse_back import kse_pkg::*; #(
  parameter int DIGIT_COUNT = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] long_press_ticks,
  input  logic       q_empty,
  input  item_t      q_item,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       display_write,
  output logic [7:0] digit_select,
  output logic [7:0] segment_pattern,
  output logic [3:0] pressed_key,
  output logic       entry_mode,
  output logic [2:0] cursor,
  output logic [2:0] led_levels
);

  localparam logic [2:0] LastDigit = 3'(DIGIT_COUNT - 1);

  logic [2:0] cursor_pos,      cursor_pos_next;
  logic       mode_flag,       mode_flag_next;
  key_t       previous_key,    previous_key_next;
  logic       previous_button;
  logic [7:0] hold_count,      hold_count_next;
  logic       long_fired,      long_fired_next;
  logic [2:0] led_state,       led_state_next;
  logic       wr;
  logic [7:0] pattern;
  logic [7:0] hold_inc;
  key_t       key;

  assign q_pop = !q_empty && (!out_valid || out_ready);
  assign key   = q_item.key;
  assign hold_inc = (hold_count == 8'hFF) ? hold_count : hold_count + 8'd1;

  always_comb begin
    cursor_pos_next   = cursor_pos;
    mode_flag_next    = mode_flag;
    hold_count_next   = hold_count;
    long_fired_next   = long_fired;
    led_state_next    = led_state;
    previous_key_next = previous_key;
    wr                = 1'b0;
    pattern           = SEG_DARK;

    // Button: long press toggles mode once, short press advances cursor
    if (!q_item.button) begin
      hold_count_next = hold_inc;
      if (hold_inc >= long_press_ticks && !long_fired) begin
        long_fired_next = 1'b1;
        mode_flag_next  = ~mode_flag;
        cursor_pos_next = '0;
        led_state_next  = LED_ALL_OFF;
      end
    end else begin
      if (hold_count != '0 && hold_count < long_press_ticks && !previous_button) begin
        cursor_pos_next = (cursor_pos >= LastDigit) ? '0 : cursor_pos + 3'd1;
      end
      hold_count_next = '0;
      long_fired_next = 1'b0;
    end

    // Key change drives a digit in the freshly updated mode; a change to no key turns the LEDs off
    if (key != previous_key) begin
      previous_key_next = key;
      if (key == KEY_NONE) begin
        led_state_next = LED_ALL_OFF;
      end else if (mode_flag_next == MODE_DIGIT) begin
        wr = 1'b1;
        if (key <= KEY_NINE) begin
          pattern        = digit_font(key);
          led_state_next = {1'b1, key == KEY_ZERO, key != KEY_ZERO};
        end else begin
          pattern        = (key == KEY_DASH) ? SEG_DASH : SEG_DOT;
          led_state_next = LED_SYMBOL;
        end
      end else begin
        if (key >= 4'd1 && key <= 4'd6) begin
          wr      = 1'b1;
          pattern = letter_font(key);
        end else if (key == 4'd7) begin
          wr      = 1'b1;
          pattern = SEG_LOW_H;
        end else if (key == 4'd8) begin
          wr      = 1'b1;
          pattern = SEG_SECOND;
        end
        if (wr) begin
          led_state_next = LED_LETTER;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_pos      <= '0;
      mode_flag       <= MODE_DIGIT;
      previous_key    <= KEY_NONE;
      previous_button <= 1'b1;
      hold_count      <= '0;
      long_fired      <= 1'b0;
      led_state       <= LED_ALL_OFF;
      out_valid       <= 1'b0;
    end else begin
      if (q_pop) begin
        cursor_pos      <= cursor_pos_next;
        mode_flag       <= mode_flag_next;
        previous_key    <= previous_key_next;
        previous_button <= q_item.button;
        hold_count      <= hold_count_next;
        long_fired      <= long_fired_next;
        led_state       <= led_state_next;
        out_valid       <= 1'b1;
      end else if (out_ready) begin
        out_valid       <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      display_write   <= wr;
      digit_select    <= wr ? ~(8'd1 << cursor_pos_next) : SEG_DARK;
      segment_pattern <= wr ? pattern : SEG_DARK;
      pressed_key     <= key;
      entry_mode      <= mode_flag_next;
      cursor          <= cursor_pos_next;
      led_levels      <= led_state_next;
    end
  end

endmodule

[hw/rtl/keypad_to_seven_segment_entry.sv]
// Top level of the keypad to seven-segment entry block.
//
// Usage:
//   Input channel (in_valid/in_ready): one transaction per scan tick, carrying
//   button_level (0 = pressed) and the 12-bit key_matrix snapshot.
//   Output channel (out_valid/out_ready): exactly one result transaction per
//   input transaction, in order: display write strobe, active-low digit
//   select and segment pattern, decoded key, mode, cursor and LED levels.
//   Config channel (cfg_valid/cfg_ready/cfg_data): writes long_press_ticks;
//   always ready, write it only while the block is idle.
// Timing:
//   An accepted tick is written into the queue; the back end pops it when
//   out_valid is low or out_ready is high, and registers its result, which
//   is valid from then on. One tick per cycle is sustained while out_ready
//   stays high; the rate is set by the back end's state update.
// Reset (rst, synchronous): clears the queue and out_valid, sets
//   digit mode, cursor 0, no key, button released, LEDs off, threshold 40.
// Stalls: when out_ready is low the result holds; the back end stops and the
//   two-entry queue fills, after which in_ready drops.
module keypad_to_seven_segment_entry import kse_pkg::*; #(
  parameter int DIGIT_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        button_level,
  input  logic [11:0] key_matrix,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        display_write,
  output logic [7:0]  digit_select,
  output logic [7:0]  segment_pattern,
  output logic [3:0]  pressed_key,
  output logic        entry_mode,
  output logic [2:0]  cursor,
  output logic [2:0]  led_levels,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic [7:0] long_press_ticks;
  logic       q_full;
  logic       q_empty;
  logic       q_push;
  logic       q_pop;
  item_t      push_item;
  item_t      pop_item;

  // Hold the threshold register; take every config transaction at once
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks <= 8'd40;
    end else if (cfg_valid) begin
      long_press_ticks <= cfg_data;
    end
  end

  // Decode the keypad snapshot on the way in
  kse_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .button_level (button_level),
    .key_matrix   (key_matrix),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (push_item)
  );

  // Buffer decoded ticks so each side can stall on its own
  kse_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Advance press, mode and cursor state and register the result
  kse_back #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .long_press_ticks (long_press_ticks),
    .q_empty          (q_empty),
    .q_item           (pop_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .display_write    (display_write),
    .digit_select     (digit_select),
    .segment_pattern  (segment_pattern),
    .pressed_key      (pressed_key),
    .entry_mode       (entry_mode),
    .cursor           (cursor),
    .led_levels       (led_levels)
  );

endmodule
